// ===== hw/rtl/cbd_pkg.sv =====
package cbd_pkg;

   localparam int LEN_DIGITS_DEF = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [3:0] PH_LEN_FIRST = 4'd0;
   localparam logic [3:0] PH_LEN_MORE  = 4'd1;
   localparam logic [3:0] PH_LEN_LF    = 4'd2;
   localparam logic [3:0] PH_DATA      = 4'd3;
   localparam logic [3:0] PH_DATA_CR   = 4'd4;
   localparam logic [3:0] PH_DATA_LF   = 4'd5;
   localparam logic [3:0] PH_END_PLAIN = 4'd6;
   localparam logic [3:0] PH_END_IEOF  = 4'd7;
   localparam logic [3:0] PH_HALT      = 4'd8;

   localparam logic [3:0] END_PLAIN_LEN = 4'd5;
   localparam logic [3:0] END_IEOF_LEN  = 4'd11;
   localparam logic [3:0] END_START_POS = 4'd2;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_EOF   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_SEMI = 8'h3b;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       chunk_last;
   } item_type;

   typedef struct packed {
      logic     vld;
      item_type item;
   } push_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // "0" CR LF CR LF
   function automatic logic [7:0] end_plain_char(logic [3:0] idx);
      logic [7:0] r;
      unique case (idx)
         4'd0: r = 8'h30;
         4'd1: r = CHAR_CR;
         4'd2: r = CHAR_LF;
         4'd3: r = CHAR_CR;
         4'd4: r = CHAR_LF;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "0; ieof" CR LF CR LF
   function automatic logic [7:0] end_ieof_char(logic [3:0] idx);
      logic [7:0] r;
      unique case (idx)
         4'd0:  r = 8'h30;
         4'd1:  r = CHAR_SEMI;
         4'd2:  r = 8'h20;
         4'd3:  r = 8'h69;
         4'd4:  r = 8'h65;
         4'd5:  r = 8'h6f;
         4'd6:  r = 8'h66;
         4'd7:  r = CHAR_CR;
         4'd8:  r = CHAR_LF;
         4'd9:  r = CHAR_CR;
         4'd10: r = CHAR_LF;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/cbd_front.sv =====
module cbd_front
   import cbd_pkg::*;
#(
   parameter int LEN_DIGITS = LEN_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   output push_type   q_wr,
   output logic       halted
);

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] remaining_len_ff, remaining_len_in;
   logic [3:0]  digit_count_ff, digit_count_in;
   logic [3:0]  match_pos_ff, match_pos_in;
   logic [4:0]  hx;
   logic        hv;
   logic [3:0]  hn;
   logic [3:0]  mp_next;

   assign hx      = hex_decode(rx_byte);
   assign hv      = hx[4];
   assign hn      = hx[3:0];
   assign mp_next = match_pos_ff + 4'd1;
   assign halted  = (phase_ff == PH_HALT);

   always_comb begin
      phase_in         = phase_ff;
      remaining_len_in = remaining_len_ff;
      digit_count_in   = digit_count_ff;
      match_pos_in     = match_pos_ff;
      q_wr.vld         = 1'b0;
      q_wr.item        = '{out_byte: 8'd0, kind: KIND_DATA, chunk_last: 1'b0};
      if (fire) begin
         unique case (phase_ff)
            PH_LEN_FIRST: begin
               if (!hv) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  remaining_len_in = {28'd0, hn};
                  digit_count_in   = 4'd0;
                  phase_in         = PH_LEN_MORE;
               end
            end
            PH_LEN_MORE: begin
               if (hv) begin
                  if ((5'(digit_count_ff) + 5'd1 >= 5'(LEN_DIGITS))
                      || (remaining_len_ff[31:28] != 4'd0)) begin
                     phase_in = PH_HALT;
                     q_wr.vld = 1'b1;
                     q_wr.item.kind = KIND_ERROR;
                  end else begin
                     remaining_len_in = {remaining_len_ff[27:0], hn};
                     digit_count_in   = digit_count_ff + 4'd1;
                  end
               end else if (remaining_len_ff == 32'd0) begin
                  if (rx_byte == CHAR_CR) begin
                     phase_in     = PH_END_PLAIN;
                     match_pos_in = END_START_POS;
                  end else if (rx_byte == CHAR_SEMI) begin
                     phase_in     = PH_END_IEOF;
                     match_pos_in = END_START_POS;
                  end else begin
                     phase_in = PH_HALT;
                     q_wr.vld = 1'b1;
                     q_wr.item.kind = KIND_ERROR;
                  end
               end else if (rx_byte == CHAR_CR) begin
                  phase_in = PH_LEN_LF;
               end else begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end
            end
            PH_LEN_LF: begin
               if (rx_byte != CHAR_LF) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               remaining_len_in     = remaining_len_ff - 32'd1;
               q_wr.vld             = 1'b1;
               q_wr.item.out_byte   = rx_byte;
               q_wr.item.chunk_last = (remaining_len_ff == 32'd1);
               if (remaining_len_ff == 32'd1) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (rx_byte != CHAR_CR) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (rx_byte != CHAR_LF) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  phase_in = PH_LEN_FIRST;
               end
            end
            PH_END_PLAIN: begin
               if (match_pos_ff >= END_PLAIN_LEN
                   || rx_byte != end_plain_char(match_pos_ff)) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  match_pos_in = mp_next;
                  if (mp_next == END_PLAIN_LEN) begin
                     phase_in = PH_HALT;
                     q_wr.vld = 1'b1;
                     q_wr.item.kind = KIND_END;
                  end
               end
            end
            PH_END_IEOF: begin
               if (match_pos_ff >= END_IEOF_LEN
                   || rx_byte != end_ieof_char(match_pos_ff)) begin
                  phase_in = PH_HALT;
                  q_wr.vld = 1'b1;
                  q_wr.item.kind = KIND_ERROR;
               end else begin
                  match_pos_in = mp_next;
                  if (mp_next == END_IEOF_LEN) begin
                     phase_in = PH_HALT;
                     q_wr.vld = 1'b1;
                     q_wr.item.kind = KIND_EOF;
                  end
               end
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEN_FIRST;
         remaining_len_ff <= 32'd0;
         digit_count_ff   <= 4'd0;
         match_pos_ff     <= 4'd0;
      end else begin
         phase_ff         <= phase_in;
         remaining_len_ff <= remaining_len_in;
         digit_count_ff   <= digit_count_in;
         match_pos_ff     <= match_pos_in;
      end
   end

endmodule

// ===== hw/rtl/cbd_queue.sv =====
module cbd_queue
   import cbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type q_wr,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = q_wr.vld && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wr.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/cbd_back.sv =====
module cbd_back
   import cbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  item_type   pop_item,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign pop      = !q_empty && (!valid_ff || rsp_tready);
   assign valid_in = pop ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = (item_ff.kind == KIND_DATA) ? item_ff.out_byte : 8'd0;
   assign rsp_tuser  = item_ff.kind;
   assign rsp_tlast  = (item_ff.kind == KIND_DATA) && item_ff.chunk_last;

endmodule

// ===== hw/rtl/chunked_body_deframer.sv =====
// Chunked message body deframer.
// req channel: one raw body byte per word in req_tdata. Hex length lines,
// payload and CRLF trailers are parsed; payload bytes come out on the rsp
// channel with rsp_tlast on the last byte of each chunk. A zero-length
// chunk ends the body: rsp_tuser reports normal end, end with ieof, or
// error for any framing violation (missing or too many length digits,
// bad line terminator, bad trailer, bad end sequence).
// Bytes that only carry framing produce no rsp word. After an end or an
// error word the block swallows all further input until reset.
// Throughput: one byte per cycle while the queue is not full.
// Path: parser (combinational) -> 4-entry queue -> output register; an
// accepted byte is written into the queue, then moved to the output register.
// Stall: when rsp_tready is low the output register holds; the queue
// absorbs up to 4 more words, then req_tready drops.
// Reset (synchronous): parser waits for the first length digit; queue
// and output are empty.
module chunked_body_deframer
   import cbd_pkg::*;
#(
   parameter int LEN_DIGITS = LEN_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   push_type q_wr;
   item_type pop_item;
   logic     q_full, q_empty, q_pop, fire, halted;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;

   cbd_front #(.LEN_DIGITS(LEN_DIGITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (req_tdata),
      .q_wr    (q_wr),
      .halted  (halted)
   );

   cbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_wr     (q_wr),
      .pop      (q_pop),
      .pop_item (pop_item),
      .full     (q_full),
      .empty    (q_empty)
   );

   cbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop_item   (pop_item),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_wr.vld |-> !q_full) else $error("push into full queue");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted |-> !q_wr.vld) else $error("word produced after halt");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted |=> halted) else $error("halt state left without reset");

   a_ctrl_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_DATA) |-> (rsp_tdata == 8'd0 && !rsp_tlast))
      else $error("end or error word carries data");

endmodule
